// ----- rtl/core/lru_pkg.sv -----
package lru_pkg;

  // Fixed field widths of the reference and result items.
  localparam int PAGE_W  = 4;
  localparam int STAMP_W = 32;
  localparam int CFG_W   = 3;
  localparam int FRAME_W = 2;

  // Reset value of the frame-count register.
  localparam logic [CFG_W-1:0]   CFG_RESET = 3'd4;
  // Saturation value of the tick and fault counters.
  localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } st_t;

  // Flags that the frame scan unit reports to the sequencer.
  typedef struct packed {
    logic hit_found;
    logic empty_found;
  } scan_flags_t;

endpackage

// ----- rtl/core/lru_ram.sv -----
module lru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/lru_scan.sv -----
module lru_scan #(
  parameter int IDX_W = 2
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             clr,
  input  logic                             en,
  input  logic [IDX_W-1:0]                 idx,
  input  logic [lru_pkg::PAGE_W-1:0]       page,
  input  logic [lru_pkg::STAMP_W-1:0]      stamp,
  input  logic [lru_pkg::PAGE_W-1:0]       target,
  output lru_pkg::scan_flags_t             flags,
  output logic [IDX_W-1:0]                 hit_idx,
  output logic [IDX_W-1:0]                 empty_idx,
  output logic [IDX_W-1:0]                 best_idx,
  output logic [lru_pkg::PAGE_W-1:0]       best_page
);
  import lru_pkg::*;

  logic               have_best;
  logic [STAMP_W-1:0] best_stamp;
  logic               older;

  // The single shared comparator: a strictly older stamp replaces the candidate,
  // so the lowest frame index wins ties.
  assign older = !have_best || (stamp < best_stamp);

  // Flags are cleared at the start of each reference.
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      flags     <= '0;
      have_best <= 1'b0;
    end else if (en) begin
      if (!flags.hit_found && page == target) begin
        flags.hit_found <= 1'b1;
      end
      if (!flags.empty_found && page == '0) begin
        flags.empty_found <= 1'b1;
      end
      if (older) begin
        have_best <= 1'b1;
      end
    end
  end

  // Candidate indices, page and stamp follow the flags.
  always_ff @(posedge clk) begin
    if (en) begin
      if (!flags.hit_found && page == target) begin
        hit_idx <= idx;
      end
      if (!flags.empty_found && page == '0) begin
        empty_idx <= idx;
      end
      if (older) begin
        best_stamp <= stamp;
        best_idx   <= idx;
        best_page  <= page;
      end
    end
  end

endmodule

// ----- rtl/core/lru_page_replacement.sv -----
// Channel   Signals                          Direction  Transfer
// request   start, busy, page                in         start high while busy low
// result    done, hit, frame, evicted_valid, out        done high for one cycle
//           evicted_page, fault_count, bad_page
// config    cfg_valid, cfg_ready, cfg_data   in         cfg_valid and cfg_ready high
//
// A valid reference scans each active frame through the frame table RAM, feeds the
// frame and timestamp read pipeline, waits to see that pipeline empty, and then
// does the update. busy falls as done rises.
// A bad page number gives done in the next cycle and never raises busy.
// Reset is synchronous; it empties all frames and clears stamps at once through
// valid bits, and clears the counters. The receiver cannot stall: each result shows once.
module lru_page_replacement #(
  parameter int MAX_FRAMES = 4,
  parameter int NUM_PAGES  = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [lru_pkg::PAGE_W-1:0]    page,
  output logic                          done,
  output logic                          hit,
  output logic [lru_pkg::FRAME_W-1:0]   frame,
  output logic                          evicted_valid,
  output logic [lru_pkg::PAGE_W-1:0]    evicted_page,
  output logic [lru_pkg::STAMP_W-1:0]   fault_count,
  output logic                          bad_page,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lru_pkg::CFG_W-1:0]     cfg_data
);
  import lru_pkg::*;

  localparam int FAW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int FCW = $clog2(MAX_FRAMES + 1);
  localparam int PAW = $clog2(NUM_PAGES);
  localparam logic [8:0] NP9   = 9'(NUM_PAGES);
  localparam logic [7:0] MAXF8 = 8'(MAX_FRAMES);

  st_t state, state_next;

  logic [CFG_W-1:0]     frames_in_use;
  logic [FCW-1:0]       n_act;
  logic [FCW-1:0]       rd_idx;
  logic [PAGE_W-1:0]    req_page;
  logic [STAMP_W-1:0]   tick;
  logic [STAMP_W-1:0]   faults;
  logic [MAX_FRAMES-1:0] fvalid;
  logic [NUM_PAGES-1:0]  svalid;

  // Read pipeline: stage 1 holds frame data, stage 2 holds the stamp.
  logic                 p1_vld, p2_vld;
  logic [FAW-1:0]       p1_idx, p2_idx;
  logic                 fv_q, sv_q;
  logic [PAGE_W-1:0]    p2_page;

  logic [PAGE_W-1:0]    f_rdata;
  logic [STAMP_W-1:0]   s_rdata;
  logic [PAGE_W-1:0]    p1_page;
  logic [PAW-1:0]       s_raddr;
  logic [PAW-1:0]       s_waddr;
  logic [STAMP_W-1:0]   p2_stamp;

  logic                 accept, is_bad, issue, decide, drained;
  logic [7:0]           cfg8, n8;

  scan_flags_t          flags;
  logic [FAW-1:0]       hit_idx, empty_idx, best_idx, slot;
  logic [PAGE_W-1:0]    best_page;
  logic [FAW+1:0]       slot_ext;
  logic                 miss;
  logic [STAMP_W-1:0]   faults_inc;

  // Page number to stamp RAM address.
  function automatic logic [PAW-1:0] page_addr(input logic [PAGE_W-1:0] p);
    logic [PAGE_W+PAW-1:0] wide;
    wide = {{PAW{1'b0}}, p - 4'd1};
    return wide[PAW-1:0];
  endfunction

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign is_bad    = (page == '0) || ({5'b0, page} > NP9);

  // Frame count clamped to the range 1 to MAX_FRAMES.
  assign cfg8 = {5'b0, frames_in_use};
  always_comb begin
    priority if (cfg8 == 8'd0) begin
      n8 = 8'd1;
    end else if (cfg8 > MAXF8) begin
      n8 = MAXF8;
    end else begin
      n8 = cfg8;
    end
  end

  // Stage 1 page and the stamp read it triggers.
  assign p1_page  = fv_q ? f_rdata : '0;
  assign s_raddr  = page_addr(p1_page);
  assign s_waddr  = page_addr(req_page);
  assign p2_stamp = sv_q ? s_rdata : '0;
  assign drained  = (rd_idx == n_act) && !p1_vld && !p2_vld;

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && !is_bad) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (drained) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    issue  = 1'b0;
    decide = 1'b0;
    unique case (state)
      ST_IDLE:   ;
      ST_SCAN:   issue = (rd_idx != n_act);
      ST_DECIDE: decide = 1'b1;
      default:   ;
    endcase
  end

  // Replacement choice: hit frame, else first empty frame, else oldest frame.
  always_comb begin
    priority if (flags.hit_found) begin
      slot = hit_idx;
    end else if (flags.empty_found) begin
      slot = empty_idx;
    end else begin
      slot = best_idx;
    end
  end
  assign miss       = !flags.hit_found;
  assign slot_ext   = {2'b00, slot};
  assign faults_inc = (faults != STAMP_MAX) ? faults + 32'd1 : faults;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      frames_in_use <= CFG_RESET;
      tick          <= '0;
      faults        <= '0;
      fvalid        <= '0;
      svalid        <= '0;
      p1_vld        <= 1'b0;
      p2_vld        <= 1'b0;
      rd_idx        <= '0;
      done          <= 1'b0;
    end else begin
      state  <= state_next;
      done   <= decide || (accept && is_bad);
      p1_vld <= issue;
      p2_vld <= p1_vld;
      if (cfg_valid && cfg_ready) begin
        frames_in_use <= cfg_data;
      end
      if (accept) begin
        rd_idx <= '0;
      end else if (issue) begin
        rd_idx <= rd_idx + 1'b1;
      end
      if (decide) begin
        svalid[s_waddr] <= 1'b1;
        tick         <= (tick != STAMP_MAX) ? tick + 32'd1 : tick;
        if (miss) begin
          faults       <= faults_inc;
          fvalid[slot] <= 1'b1;
        end
      end
    end
  end

  // Payload and pipeline registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_page <= page;
      n_act    <= n8[FCW-1:0];
      if (is_bad) begin
        hit           <= 1'b0;
        frame         <= '0;
        evicted_valid <= 1'b0;
        evicted_page  <= '0;
        fault_count   <= faults;
        bad_page      <= 1'b1;
      end
    end
    if (issue) begin
      fv_q   <= fvalid[rd_idx[FAW-1:0]];
      p1_idx <= rd_idx[FAW-1:0];
    end
    if (p1_vld) begin
      sv_q    <= (p1_page != '0) && svalid[s_raddr];
      p2_idx  <= p1_idx;
      p2_page <= p1_page;
    end
    if (decide) begin
      hit           <= flags.hit_found;
      frame         <= slot_ext[FRAME_W-1:0];
      evicted_valid <= miss && !flags.empty_found;
      evicted_page  <= (miss && !flags.empty_found) ? best_page : '0;
      fault_count   <= miss ? faults_inc : faults;
      bad_page      <= 1'b0;
    end
  end

  // Resident page per frame.
  lru_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (MAX_FRAMES),
    .AW    (FAW)
  ) u_frame_ram (
    .clk   (clk),
    .we    (decide && miss),
    .waddr (slot),
    .wdata (req_page),
    .raddr (rd_idx[FAW-1:0]),
    .rdata (f_rdata)
  );

  // Last-use stamp per page.
  lru_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (NUM_PAGES),
    .AW    (PAW)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (decide),
    .waddr (s_waddr),
    .wdata (tick),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  // Hit, empty and oldest-stamp search over the scanned frames.
  lru_scan #(
    .IDX_W (FAW)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .clr       (accept),
    .en        (p2_vld),
    .idx       (p2_idx),
    .page      (p2_page),
    .stamp     (p2_stamp),
    .target    (req_page),
    .flags     (flags),
    .hit_idx   (hit_idx),
    .empty_idx (empty_idx),
    .best_idx  (best_idx),
    .best_page (best_page)
  );

  // A result appears only after an update or a rejected page number.
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_DECIDE) || $past(accept))
    else $error("result without an update or a rejected reference");

  // A hit never evicts a page.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    done && hit |-> !evicted_valid)
    else $error("hit reported together with an eviction");

  // A rejected page leaves the frame fields clear.
  a_bad_clear: assert property (@(posedge clk) disable iff (rst)
    done && bad_page |-> !hit && !evicted_valid && frame == '0)
    else $error("rejected reference carries frame information");

  // The fault counter never goes backward.
  a_faults_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> faults >= $past(faults))
    else $error("fault counter decreased");

endmodule
